### rtl/fiv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fiv_pkg: shared constants of the firmware image verifier
// SHA-256 tables and functions, register indexes, verdict codes, widths.
// ----------------------------------------------------------------------------
package fiv_pkg;

  localparam int MAX_IMAGE_BYTES  = 1048576;
  localparam int MAX_MARKER_BYTES = 8;

  localparam int LEN_W   = 21;
  localparam int MLEN_W  = 4;
  localparam int CFG_W   = 64;
  localparam int CIDX_W  = 4;
  localparam int BYTE_W  = 8;
  localparam int VERD_W  = 2;

  localparam logic [CIDX_W-1:0] REG_IMAGE_LENGTH  = 4'd0;
  localparam logic [CIDX_W-1:0] REG_APP_BASE      = 4'd1;
  localparam logic [CIDX_W-1:0] REG_DIGEST_0      = 4'd2;
  localparam logic [CIDX_W-1:0] REG_DIGEST_1      = 4'd3;
  localparam logic [CIDX_W-1:0] REG_DIGEST_2      = 4'd4;
  localparam logic [CIDX_W-1:0] REG_DIGEST_3      = 4'd5;
  localparam logic [CIDX_W-1:0] REG_MARKER_BYTES  = 4'd6;
  localparam logic [CIDX_W-1:0] REG_MARKER_LENGTH = 4'd7;

  localparam logic [VERD_W-1:0] VERDICT_OK         = 2'd0;
  localparam logic [VERD_W-1:0] VERDICT_BAD_VECTOR = 2'd1;
  localparam logic [VERD_W-1:0] VERDICT_BAD_DIGEST = 2'd2;
  localparam logic [VERD_W-1:0] VERDICT_NO_MARKER  = 2'd3;

  localparam logic [31:0] STACK_LOW  = 32'h2000_0000;
  localparam logic [31:0] STACK_HIGH = 32'h2002_0000;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage
`default_nettype wire

### rtl/fiv_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fiv_if: request channels of the firmware image verifier
// Image byte channel and verdict channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface fiv_byte_if import fiv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] image_byte;
  modport source (output valid, output image_byte, input ready);
  modport sink   (input valid, input image_byte, output ready);
endinterface

interface fiv_verdict_if import fiv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VERD_W-1:0] verdict;
  modport source (output valid, output verdict, input ready);
  modport sink   (input valid, input verdict, output ready);
endinterface
`default_nettype wire

### rtl/firmware_image_verifier.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// firmware_image_verifier: SHA-256 and vector table check of an image
// Byte-serial image check with one shared SHA-256 round unit.
// ----------------------------------------------------------------------------
// Usage:
//   byte_in carries image bytes in order, one request each. A byte is taken
//   while the block is idle. Every 64th byte starts a block compression:
//   64 rounds on the single round unit (S_ROUND), then a fold into the hash
//   (S_ADD), with byte_in.ready low throughout, so no byte is taken while a
//   block is compressed. After the byte that reaches the clamped image_length
//   the block pads the message (S_PAD), runs one or two more compressions
//   (the second when eight or fewer bytes are left in the last block),
//   compares the digest and then raises verdict_out.valid.
//   The verdict waits in an output register; the next image may start while
//   it waits. A second verdict is held back until the first is taken, and
//   byte_in stays not ready meanwhile.
//   Configuration is written through cfg_we/cfg_index/cfg_data; the user
//   must write it only when idle, as the block does not enforce this.
//   Reset (synchronous) restores register defaults and clears the image
//   state; no memory clear pass is needed.
// ----------------------------------------------------------------------------
module firmware_image_verifier import fiv_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  fiv_byte_if.sink               byte_in,
  fiv_verdict_if.source          verdict_out,
  input  wire logic              cfg_we,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROUND = 3'd1;
  localparam logic [2:0] S_ADD   = 3'd2;
  localparam logic [2:0] S_PAD   = 3'd3;
  localparam logic [2:0] S_LEN   = 3'd4;
  localparam logic [2:0] S_CHECK = 3'd5;

  // which compression is running
  localparam logic [1:0] PH_DATA  = 2'd0;
  localparam logic [1:0] PH_PAD1  = 2'd1;
  localparam logic [1:0] PH_FINAL = 2'd2;

  // configuration
  logic [LEN_W-1:0]  image_length;
  logic [31:0]       app_base;
  logic [255:0]      digest_exp;
  logic [63:0]       marker_bytes;
  logic [MLEN_W-1:0] marker_length;

  // image state
  logic [2:0]        state;
  logic [1:0]        phase;
  logic              pending_final;
  logic [5:0]        rnd;
  logic [31:0]       hash [8];
  logic [31:0]       v [8];
  logic [31:0]       w [16];   // message window, doubles as block buffer
  logic [LEN_W-1:0]  bytes_seen;
  logic [63:0]       vector_words;
  logic              vector_bad;
  logic [MLEN_W-1:0] match_count;
  logic              marker_seen;
  logic              out_valid;
  logic [VERD_W-1:0] out_verdict;

  assign byte_in.ready       = (state == S_IDLE);
  assign verdict_out.valid   = out_valid;
  assign verdict_out.verdict = out_verdict;

  wire accept = byte_in.valid && byte_in.ready;
  wire [BYTE_W-1:0] b = byte_in.image_byte;

  // verdict goes out once any earlier one has drained
  wire check_fire = (state == S_CHECK) && (!out_valid || verdict_out.ready);

  // effective lengths after clamping
  logic [LEN_W-1:0]  len_eff;
  logic [MLEN_W-1:0] mlen_eff;
  always_comb begin
    len_eff = {image_length[LEN_W-1:2], 2'b00};
    if (len_eff < LEN_W'(8)) len_eff = LEN_W'(8);
    if (len_eff > LEN_W'(MAX_IMAGE_BYTES)) len_eff = LEN_W'(MAX_IMAGE_BYTES);
    mlen_eff = marker_length;
    if (mlen_eff == '0) mlen_eff = MLEN_W'(1);
    if (mlen_eff > MLEN_W'(MAX_MARKER_BYTES)) mlen_eff = MLEN_W'(MAX_MARKER_BYTES);
  end

  // per-byte bookkeeping: count, vector words, marker scan
  logic [LEN_W-1:0]  seen_next;
  logic [63:0]       vec_next;
  logic              vec_bad_next;
  logic [MLEN_W-1:0] mc_start, mc_next;
  logic              seen_marker_next;
  logic [31:0]       sp, rv;
  always_comb begin
    seen_next = bytes_seen + LEN_W'(1);
    vec_next  = vector_words;
    if (bytes_seen < LEN_W'(8)) vec_next[{bytes_seen[2:0], 3'b000} +: 8] = b;
    sp = vec_next[31:0];
    rv = vec_next[63:32];
    vec_bad_next = vector_bad;
    if (seen_next == LEN_W'(8)) begin
      if (sp <= STACK_LOW || sp > STACK_HIGH || sp[2:0] != 3'b000 || !rv[0] ||
          rv < app_base ||
          {1'b0, rv[31:1], 1'b0} >= ({1'b0, app_base} + 33'(len_eff)))
        vec_bad_next = 1'b1;
    end
    mc_start = (match_count >= mlen_eff) ? '0 : match_count;
    if (b == marker_bytes[{mc_start[2:0], 3'b000} +: 8]) mc_next = mc_start + MLEN_W'(1);
    else mc_next = (b == marker_bytes[7:0]) ? MLEN_W'(1) : '0;
    seen_marker_next = marker_seen;
    if (mc_next == mlen_eff) begin
      seen_marker_next = 1'b1;
      mc_next = '0;
    end
  end

  // shared round unit
  logic [31:0] t1, t2, w_new;
  always_comb begin
    t1 = v[7] + bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[rnd] + w[0];
    t2 = bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    w_new = w[0] + sig0(w[1]) + w[9] + sig1(w[14]);
  end

  // padded last block: keep bytes below fill, 0x80 at fill, zero above;
  // the bit count goes in the last two words when it fits
  logic [5:0]  fill;
  logic [31:0] w_pad [16];
  logic [31:0] bit_count;
  always_comb begin
    fill = bytes_seen[5:0];
    bit_count = {8'd0, bytes_seen, 3'b000};
    for (int i = 0; i < 16; i++) begin
      for (int k = 0; k < 4; k++) begin
        if (6'(4 * i + k) < fill) w_pad[i][31-8*k -: 8] = w[i][31-8*k -: 8];
        else if (6'(4 * i + k) == fill) w_pad[i][31-8*k -: 8] = 8'h80;
        else w_pad[i][31-8*k -: 8] = 8'h00;
      end
    end
    if (fill < 6'd56) begin
      w_pad[14] = '0;
      w_pad[15] = bit_count;
    end
  end

  // digest compare, expected bytes stored byte 0 in low bits
  logic digest_ok;
  always_comb begin
    digest_ok = 1'b1;
    for (int k = 0; k < 8; k++) begin
      if (hash[k] != {digest_exp[32*k +: 8], digest_exp[32*k+8 +: 8],
                      digest_exp[32*k+16 +: 8], digest_exp[32*k+24 +: 8]})
        digest_ok = 1'b0;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_length  <= LEN_W'(8);
      app_base      <= '0;
      digest_exp    <= '0;
      marker_bytes  <= '0;
      marker_length <= MLEN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_LENGTH:  image_length       <= cfg_data[LEN_W-1:0];
        REG_APP_BASE:      app_base           <= cfg_data[31:0];
        REG_DIGEST_0:      digest_exp[63:0]   <= cfg_data;
        REG_DIGEST_1:      digest_exp[127:64] <= cfg_data;
        REG_DIGEST_2:      digest_exp[191:128] <= cfg_data;
        REG_DIGEST_3:      digest_exp[255:192] <= cfg_data;
        REG_MARKER_BYTES:  marker_bytes       <= cfg_data;
        REG_MARKER_LENGTH: marker_length      <= cfg_data[MLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      phase         <= PH_DATA;
      pending_final <= 1'b0;
      rnd           <= '0;
      for (int i = 0; i < 8; i++) hash[i] <= H_INIT[i];
      bytes_seen    <= '0;
      vector_words  <= '0;
      vector_bad    <= 1'b0;
      match_count   <= '0;
      marker_seen   <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (check_fire) out_valid <= 1'b1;
      else if (out_valid && verdict_out.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            w[bytes_seen[5:2]][31-8*bytes_seen[1:0] -: 8] <= b;
            bytes_seen   <= seen_next;
            vector_words <= vec_next;
            vector_bad   <= vec_bad_next;
            match_count  <= mc_next;
            marker_seen  <= seen_marker_next;
            pending_final <= (seen_next >= len_eff);
            if (seen_next[5:0] == 6'd0) begin
              phase <= PH_DATA;
              rnd   <= '0;
              for (int i = 0; i < 8; i++) v[i] <= hash[i];
              state <= S_ROUND;
            end else if (seen_next >= len_eff) begin
              state <= S_PAD;
            end
          end
        end
        S_ROUND: begin
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= w_new;
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) state <= S_ADD;
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) hash[i] <= hash[i] + v[i];
          unique case (phase)
            PH_PAD1:  state <= S_LEN;
            PH_FINAL: state <= S_CHECK;
            default:  state <= pending_final ? S_PAD : S_IDLE;
          endcase
        end
        S_PAD: begin
          for (int i = 0; i < 16; i++) w[i] <= w_pad[i];
          rnd <= '0;
          for (int i = 0; i < 8; i++) v[i] <= hash[i];
          if (fill < 6'd56) begin
            phase <= PH_FINAL;
          end else begin
            phase <= PH_PAD1;
          end
          state <= S_ROUND;
        end
        S_LEN: begin
          for (int i = 0; i < 14; i++) w[i] <= '0;
          w[14] <= '0;
          w[15] <= bit_count;
          rnd <= '0;
          for (int i = 0; i < 8; i++) v[i] <= hash[i];
          phase <= PH_FINAL;
          state <= S_ROUND;
        end
        S_CHECK: begin
          // wait for a previous verdict to drain
          if (check_fire) begin
            priority if (vector_bad) out_verdict <= VERDICT_BAD_VECTOR;
            else if (!digest_ok)     out_verdict <= VERDICT_BAD_DIGEST;
            else if (!marker_seen)   out_verdict <= VERDICT_NO_MARKER;
            else                     out_verdict <= VERDICT_OK;
            for (int i = 0; i < 8; i++) hash[i] <= H_INIT[i];
            bytes_seen    <= '0;
            vector_words  <= '0;
            vector_bad    <= 1'b0;
            match_count   <= '0;
            marker_seen   <= 1'b0;
            pending_final <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_round_steps: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && rnd != 6'd63) |=> (state == S_ROUND && rnd == $past(rnd) + 6'd1))
    else $error("round counter skipped");

  a_verdict_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_CHECK)
    else $error("verdict raised outside check");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    bytes_seen <= LEN_W'(MAX_IMAGE_BYTES))
    else $error("byte count beyond maximum image");

endmodule
`default_nettype wire
